>>> hw/rtl/lgt_pkg.sv
// shared types and constants for the toroidal life generation unit
package lgt_pkg;

   localparam int DIM_W     = 7;
   localparam int CMD_W     = 2;
   localparam int COORD_W   = 6;
   localparam int MIN_DIM   = 3;
   localparam int RESET_DIM = 64;
   localparam int CSR_DW    = 32;
   localparam int CSR_AW    = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_STEP  = 2'd3
   } cmd_type;

   // register index as decoded from the word address bit
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // 3x3 window around one cell: bit 0 left, bit 1 centre, bit 2 right
   typedef struct packed {
      logic [2:0] up;
      logic [2:0] mid;
      logic [2:0] dn;
   } nbr_type;

endpackage

>>> hw/rtl/lgt_cell_unit.sv
// neighbour count and B3/S23 rule for one cell
module lgt_cell_unit
   import lgt_pkg::*;
(
   input  nbr_type window,
   output logic    next_alive
);

   logic [3:0] count;
   logic [7:0] nbrs;

   assign nbrs = {window.up, window.mid[2], window.mid[0], window.dn};

   always_comb begin
      count = 4'd0;
      for (int i = 0; i < 8; i++) begin
         count = count + 4'(nbrs[i]);
      end
   end

   assign next_alive = (count == 4'd3) || (window.mid[1] && (count == 4'd2));

endmodule

>>> hw/rtl/life_generation_torus_unit.sv
// toroidal life grid: cell write/read, clear and generation step under a row sequencer
// write or read: S_CELL then S_RESP; a bad coordinate goes straight to S_RESP
// clear: S_CLEAR zeroes every row of the current bank, then S_RESP answers
// step: every row of the store is visited; a row in use is fetched, swept and written,
// a row outside the grid in use is copied, all limited by the single row memory port
// one transaction at a time; the next is accepted once the response is registered
// reset: a clearing pass over MAX_ROWS rows zeroes the grid before the first transaction
module life_generation_torus_unit
   import lgt_pkg::*;
#(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [COORD_W-1:0] req_row,
   input  logic [COORD_W-1:0] req_col,
   input  logic               req_cell_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_cell_alive,
   output logic               rsp_bad_coordinate,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int CW      = $clog2(MAX_COLS + 1);
   localparam int CH      = $clog2(MAX_ROWS + 1);
   localparam int CMPW_A  = (CW > CH) ? CW : CH;
   localparam int CMPW    = (CMPW_A > DIM_W) ? CMPW_A : DIM_W;
   localparam int ROWS_P2 = 1 << ROW_W;
   localparam int ADDR_W  = ROW_W + 1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CELL,
      S_FETCH_UP,
      S_FETCH_MID,
      S_FETCH_DN,
      S_LOAD_DN,
      S_SWEEP,
      S_WRITE_ROW,
      S_RESP
   } state_type;

   // configuration registers
   logic [DIM_W-1:0] grid_width_ff, grid_width_in;
   logic [DIM_W-1:0] grid_height_ff, grid_height_in;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_GRID_WIDTH:  grid_width_in  = pwdata[DIM_W-1:0];
            REG_GRID_HEIGHT: grid_height_in = pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= DIM_W'(RESET_DIM);
         grid_height_ff <= DIM_W'(RESET_DIM);
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? CSR_DW'(grid_height_ff)
                                                 : CSR_DW'(grid_width_ff);

   // clamped dimensions
   logic [CMPW-1:0] w_raw, h_raw;
   logic [CW-1:0]   w_eff;
   logic [CH-1:0]   h_eff;

   assign w_raw = CMPW'(grid_width_ff);
   assign h_raw = CMPW'(grid_height_ff);

   always_comb begin
      if (w_raw < CMPW'(MIN_DIM)) begin
         w_eff = CW'(MIN_DIM);
      end else if (w_raw > CMPW'(MAX_COLS)) begin
         w_eff = CW'(MAX_COLS);
      end else begin
         w_eff = w_raw[CW-1:0];
      end
      if (h_raw < CMPW'(MIN_DIM)) begin
         h_eff = CH'(MIN_DIM);
      end else if (h_raw > CMPW'(MAX_ROWS)) begin
         h_eff = CH'(MAX_ROWS);
      end else begin
         h_eff = h_raw[CH-1:0];
      end
   end

   // row memory, two banks
   logic [MAX_COLS-1:0] grid_mem [2*ROWS_P2];
   logic [MAX_COLS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [MAX_COLS-1:0] mem_wr_data;
   logic                mem_wr_en;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         grid_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= grid_mem[mem_rd_addr];
   end

   // sequencer registers
   state_type           state_ff, state_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                sel_ff, sel_in;
   logic                from_reset_ff, from_reset_in;
   cmd_type             cmd_ff, cmd_in;
   logic [COORD_W-1:0]  req_row_ff, req_row_in;
   logic [COORD_W-1:0]  req_col_ff, req_col_in;
   logic                value_ff, value_in;
   logic [MAX_COLS-1:0] up_row_ff, up_row_in;
   logic [MAX_COLS-1:0] mid_row_ff, mid_row_in;
   logic [MAX_COLS-1:0] dn_row_ff, dn_row_in;
   logic [MAX_COLS-1:0] new_row_ff, new_row_in;
   logic                res_alive_ff, res_alive_in;
   logic                res_bad_ff, res_bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_alive_ff, rsp_alive_in;
   logic                rsp_bad_ff, rsp_bad_in;

   // row and column wrap
   logic [CH-1:0]    r_ext, r_inc;
   logic [ROW_W-1:0] up_idx, dn_idx;
   logic             row_in_use, last_row;
   logic [CW-1:0]    c_ext, c_inc;
   logic [COL_W-1:0] lf_idx, rt_idx;
   logic             last_col;

   assign r_ext      = CH'(row_ff);
   assign r_inc      = r_ext + CH'(1);
   assign row_in_use = r_ext < h_eff;
   assign last_row   = row_ff == ROW_W'(MAX_ROWS - 1);
   assign up_idx     = (row_ff == '0) ? ROW_W'(h_eff - CH'(1)) : ROW_W'(r_ext - CH'(1));
   assign dn_idx     = (r_inc >= h_eff) ? '0 : ROW_W'(r_inc);

   assign c_ext    = CW'(col_ff);
   assign c_inc    = c_ext + CW'(1);
   assign last_col = c_inc == w_eff;
   assign lf_idx   = (col_ff == '0) ? COL_W'(w_eff - CW'(1)) : COL_W'(c_ext - CW'(1));
   assign rt_idx   = (c_inc >= w_eff) ? '0 : COL_W'(c_inc);

   nbr_type window;
   logic    next_alive;

   assign window.up  = {up_row_ff[rt_idx], up_row_ff[col_ff], up_row_ff[lf_idx]};
   assign window.mid = {mid_row_ff[rt_idx], mid_row_ff[col_ff], mid_row_ff[lf_idx]};
   assign window.dn  = {dn_row_ff[rt_idx], dn_row_ff[col_ff], dn_row_ff[lf_idx]};

   lgt_cell_unit u_cell (
      .window     (window),
      .next_alive (next_alive)
   );

   // input coordinate check
   logic             req_bad;
   logic             req_fire;
   cmd_type          req_cmd_t;
   logic [COL_W-1:0] cell_col;

   assign req_cmd_t = cmd_type'(req_cmd);
   assign req_bad   = (CMPW'(req_row) >= CMPW'(h_eff)) || (CMPW'(req_col) >= CMPW'(w_eff));
   assign req_ready = state_ff == S_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign cell_col  = COL_W'(req_col_ff);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      sel_in        = sel_ff;
      from_reset_in = from_reset_ff;
      cmd_in        = cmd_ff;
      req_row_in    = req_row_ff;
      req_col_in    = req_col_ff;
      value_in      = value_ff;
      up_row_in     = up_row_ff;
      mid_row_in    = mid_row_ff;
      dn_row_in     = dn_row_ff;
      new_row_in    = new_row_ff;
      res_alive_in  = res_alive_ff;
      res_bad_in    = res_bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_alive_in  = rsp_alive_ff;
      rsp_bad_in    = rsp_bad_ff;
      mem_rd_addr   = {sel_ff, row_ff};
      mem_wr_addr   = {~sel_ff, row_ff};
      mem_wr_data   = new_row_ff;
      mem_wr_en     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_addr = {sel_ff, row_ff};
            mem_wr_data = '0;
            mem_wr_en   = 1'b1;
            row_in      = row_ff + ROW_W'(1);
            if (last_row) begin
               row_in        = '0;
               from_reset_in = 1'b0;
               res_alive_in  = 1'b0;
               res_bad_in    = 1'b0;
               state_in      = from_reset_ff ? S_IDLE : S_RESP;
            end
         end
         S_IDLE: begin
            mem_rd_addr = {sel_ff, ROW_W'(req_row)};
            if (req_fire) begin
               cmd_in     = req_cmd_t;
               req_row_in = req_row;
               req_col_in = req_col;
               value_in   = req_cell_value;
               row_in     = '0;
               unique case (req_cmd_t)
                  CMD_WRITE, CMD_READ: begin
                     if (req_bad) begin
                        res_alive_in = 1'b0;
                        res_bad_in   = 1'b1;
                        state_in     = S_RESP;
                     end else begin
                        state_in = S_CELL;
                     end
                  end
                  CMD_CLEAR: state_in = S_CLEAR;
                  CMD_STEP:  state_in = S_FETCH_UP;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_CELL: begin
            new_row_in           = rd_data_ff;
            new_row_in[cell_col] = value_ff;
            mem_wr_addr          = {sel_ff, ROW_W'(req_row_ff)};
            mem_wr_data          = new_row_in;
            mem_wr_en            = cmd_ff == CMD_WRITE;
            res_alive_in         = (cmd_ff == CMD_WRITE) ? value_ff : rd_data_ff[cell_col];
            res_bad_in           = 1'b0;
            state_in             = S_RESP;
         end
         S_FETCH_UP: begin
            mem_rd_addr = {sel_ff, row_in_use ? up_idx : row_ff};
            state_in    = S_FETCH_MID;
         end
         S_FETCH_MID: begin
            if (row_in_use) begin
               up_row_in = rd_data_ff;
               state_in  = S_FETCH_DN;
            end else begin
               // row outside the grid in use is copied unchanged
               mem_wr_data = rd_data_ff;
               mem_wr_en   = 1'b1;
               row_in      = row_ff + ROW_W'(1);
               state_in    = S_FETCH_UP;
               if (last_row) begin
                  row_in       = '0;
                  sel_in       = ~sel_ff;
                  res_alive_in = 1'b0;
                  res_bad_in   = 1'b0;
                  state_in     = S_RESP;
               end
            end
         end
         S_FETCH_DN: begin
            mem_rd_addr = {sel_ff, dn_idx};
            mid_row_in  = rd_data_ff;
            state_in    = S_LOAD_DN;
         end
         S_LOAD_DN: begin
            dn_row_in  = rd_data_ff;
            new_row_in = mid_row_ff;
            col_in     = '0;
            state_in   = S_SWEEP;
         end
         S_SWEEP: begin
            new_row_in[col_ff] = next_alive;
            col_in             = col_ff + COL_W'(1);
            if (last_col) begin
               col_in   = '0;
               state_in = S_WRITE_ROW;
            end
         end
         S_WRITE_ROW: begin
            mem_wr_en = 1'b1;
            row_in    = row_ff + ROW_W'(1);
            state_in  = S_FETCH_UP;
            if (last_row) begin
               row_in       = '0;
               sel_in       = ~sel_ff;
               res_alive_in = 1'b0;
               res_bad_in   = 1'b0;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = res_alive_ff;
               rsp_bad_in   = res_bad_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         row_ff        <= '0;
         col_ff        <= '0;
         sel_ff        <= 1'b0;
         from_reset_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         sel_ff        <= sel_in;
         from_reset_ff <= from_reset_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      req_row_ff   <= req_row_in;
      req_col_ff   <= req_col_in;
      value_ff     <= value_in;
      up_row_ff    <= up_row_in;
      mid_row_ff   <= mid_row_in;
      dn_row_ff    <= dn_row_in;
      new_row_ff   <= new_row_in;
      res_alive_ff <= res_alive_in;
      res_bad_ff   <= res_bad_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_alive     = rsp_alive_ff;
   assign rsp_bad_coordinate = rsp_bad_ff;

   // the block is not ready in the cycle after it accepts a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on consecutive cycles");

   // step writes only go to the bank that is not current
   a_step_other_bank: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE_ROW |-> mem_wr_addr[ROW_W] != sel_ff)
      else $error("step wrote into the current bank");

   // no response can be pending and no request accepted during the post-reset clearing pass
   a_reset_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR && from_reset_ff |-> !rsp_valid_ff && !req_ready)
      else $error("activity during reset clearing pass");

   // a bad coordinate never reports a live cell
   a_bad_not_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_coordinate |-> !rsp_cell_alive)
      else $error("bad coordinate with live cell");

endmodule

>>> tb/tb_life_generation_torus_unit.sv
// self-checking testbench for the toroidal life generation unit
`timescale 1ns / 100ps

module tb_life_generation_torus_unit;
   import lgt_pkg::*;

   localparam int MODEL_COLS = 64;
   localparam int MODEL_ROWS = 64;
   localparam int MODEL_CELLS = MODEL_COLS * MODEL_ROWS;
   localparam int SWAP_IDLE_AT = 50;
   localparam int CALM_AT = 100;
   localparam int PHASES = 10;

   typedef struct {
      cmd_type            cmd;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               value;
   } grid_cmd_type;

   typedef struct {
      logic alive;
      logic bad;
   } cell_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [CMD_W-1:0]   req_cmd = '0;
   logic [COORD_W-1:0] req_row = '0;
   logic [COORD_W-1:0] req_col = '0;
   logic               req_cell_value = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_cell_alive;
   logic               rsp_bad_coordinate;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [CSR_AW-1:0]  paddr = '0;
   logic [CSR_DW-1:0]  pwdata = '0;
   logic [CSR_DW-1:0]  prdata;
   logic               pready;

   life_generation_torus_unit #(
      .MAX_COLS(MODEL_COLS),
      .MAX_ROWS(MODEL_ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_row(req_row),
      .req_col(req_col),
      .req_cell_value(req_cell_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_alive(rsp_cell_alive),
      .rsp_bad_coordinate(rsp_bad_coordinate),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // life model state
   bit         life_grid [2][MODEL_CELLS];
   bit         live_sel = 1'b0;
   logic [DIM_W-1:0] cfg_width = DIM_W'(RESET_DIM);
   logic [DIM_W-1:0] cfg_height = DIM_W'(RESET_DIM);

   grid_cmd_type    cmd_backlog[$];
   cell_result_type predicted_results[$];
   grid_cmd_type    on_wire;
   cell_result_type want;

   int issued_count = 0;
   int accepted = 0;
   int checked_count = 0;
   int mismatches = 0;
   int n_writes = 0, n_reads = 0, n_clears = 0, n_steps = 0, n_bad = 0;
   int n_sizes = 0;
   int phase_w [PHASES] = '{3, 0, 5, 127, 3, 8, 64, 13, 1, 6};
   int phase_h [PHASES] = '{3, 2, 4, 3, 65, 6, 64, 7, 9, 127};

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("timeout with %0d of %0d responses checked", checked_count, issued_count);
      $display("status: fail");
      $finish;
   end

   function automatic int clamp_dim(int v, int maxv);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int cell_of(bit sel, int r, int c);
      return int'(life_grid[sel][r * MODEL_COLS + c]);
   endfunction

   function automatic int idle_pct(bit for_sender);
      if (accepted < SWAP_IDLE_AT) return for_sender ? 34 : 59;
      if (accepted < CALM_AT) return for_sender ? 59 : 34;
      return 0;
   endfunction

   function automatic cell_result_type predict_result(grid_cmd_type t);
      cell_result_type res;
      int w, h, r, c, n, up, dn, lf, rt, i;
      bit nxt;
      w = clamp_dim(int'(cfg_width), MODEL_COLS);
      h = clamp_dim(int'(cfg_height), MODEL_ROWS);
      nxt = ~live_sel;
      res.alive = 1'b0;
      res.bad = 1'b0;
      case (t.cmd)
         CMD_WRITE, CMD_READ: begin
            if (t.cmd == CMD_WRITE) n_writes++;
            else n_reads++;
            if (int'(t.row) >= h || int'(t.col) >= w) begin
               res.bad = 1'b1;
               n_bad++;
            end else begin
               if (t.cmd == CMD_WRITE) life_grid[live_sel][t.row * MODEL_COLS + t.col] = t.value;
               res.alive = life_grid[live_sel][t.row * MODEL_COLS + t.col];
            end
         end
         CMD_CLEAR: begin
            n_clears++;
            for (i = 0; i < MODEL_CELLS; i++) life_grid[live_sel][i] = 1'b0;
         end
         default: begin
            n_steps++;
            for (i = 0; i < MODEL_CELLS; i++) life_grid[nxt][i] = life_grid[live_sel][i];
            for (r = 0; r < h; r++) begin
               for (c = 0; c < w; c++) begin
                  up = (r == 0) ? h - 1 : r - 1;
                  dn = (r + 1 >= h) ? 0 : r + 1;
                  lf = (c == 0) ? w - 1 : c - 1;
                  rt = (c + 1 >= w) ? 0 : c + 1;
                  n = cell_of(live_sel, up, lf) + cell_of(live_sel, up, c)
                    + cell_of(live_sel, up, rt) + cell_of(live_sel, r, lf)
                    + cell_of(live_sel, r, rt) + cell_of(live_sel, dn, lf)
                    + cell_of(live_sel, dn, c) + cell_of(live_sel, dn, rt);
                  if (cell_of(live_sel, r, c) != 0)
                     life_grid[nxt][r * MODEL_COLS + c] = (n == 2 || n == 3);
                  else
                     life_grid[nxt][r * MODEL_COLS + c] = (n == 3);
               end
            end
            live_sel = nxt;
         end
      endcase
      return res;
   endfunction

   task automatic issue(cmd_type op, int r, int c, int v);
      grid_cmd_type t;
      t.cmd = op;
      t.row = COORD_W'(r);
      t.col = COORD_W'(c);
      t.value = v[0];
      cmd_backlog.push_back(t);
      issued_count++;
   endtask

   task automatic settle();
      while (checked_count < issued_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_index, int value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_AW'({reg_index, 2'b00});
      pwdata <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_grid(int w, int h);
      csr_write(REG_GRID_WIDTH, w);
      cfg_width = DIM_W'(w);
      csr_write(REG_GRID_HEIGHT, h);
      cfg_height = DIM_W'(h);
      n_sizes++;
      @(negedge clock);
   endtask

   // seed the grid, then let it evolve and probe it, with some random noise mixed in
   task automatic queue_random_phase(int n);
      int w, h, k, roll;
      w = clamp_dim(int'(cfg_width), MODEL_COLS);
      h = clamp_dim(int'(cfg_height), MODEL_ROWS);
      issue(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 12)
            issue(cmd_type'(CMD_W'($urandom_range(0, 3))), $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom_range(0, 1));
         else if (2 * k < n)
            issue(CMD_WRITE, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                  ($urandom_range(0, 99) < 75) ? 1 : 0);
         else if (roll < 35)
            issue(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
         else
            issue(CMD_READ, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                  $urandom_range(0, 1));
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_results.push_back(predict_result(on_wire));
            accepted++;
         end
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
               on_wire = cmd_backlog.pop_front();
               req_cmd <= on_wire.cmd;
               req_row <= on_wire.row;
               req_col <= on_wire.col;
               req_cell_value <= on_wire.value;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: alive=%0b bad=%0b",
                           rsp_cell_alive, rsp_bad_coordinate);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_cell_alive !== want.alive || rsp_bad_coordinate !== want.bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("transaction %0d: expected alive=%0b bad=%0b, got alive=%0b bad=%0b",
                              checked_count, want.alive, want.bad,
                              rsp_cell_alive, rsp_bad_coordinate);
               end
            end
            checked_count++;
         end
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
   end

   initial begin
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners form a block across both wraps at the full size
      issue(CMD_READ, 0, 0, 0);
      issue(CMD_WRITE, 63, 63, 1);
      issue(CMD_WRITE, 0, 0, 1);
      issue(CMD_WRITE, 0, 63, 1);
      issue(CMD_WRITE, 63, 0, 1);
      issue(CMD_WRITE, 0, 0, 0);
      issue(CMD_WRITE, 0, 0, 1);
      issue(CMD_STEP, 0, 0, 0);
      issue(CMD_READ, 63, 63, 0);
      issue(CMD_READ, 1, 1, 0);
      issue(CMD_CLEAR, 63, 63, 1);
      issue(CMD_READ, 0, 0, 0);
      issue(CMD_WRITE, 10, 10, 1);
      settle();

      // small grid: out of range coordinates, blinker, untouched cell beyond the grid
      set_grid(5, 4);
      issue(CMD_WRITE, 3, 4, 1);
      issue(CMD_WRITE, 4, 0, 1);
      issue(CMD_WRITE, 0, 5, 1);
      issue(CMD_READ, 63, 63, 0);
      issue(CMD_WRITE, 1, 1, 1);
      issue(CMD_WRITE, 1, 2, 1);
      issue(CMD_WRITE, 1, 3, 1);
      issue(CMD_STEP, 0, 0, 0);
      issue(CMD_READ, 0, 2, 0);
      issue(CMD_READ, 10, 10, 0);
      settle();

      set_grid(127, 64);
      issue(CMD_READ, 10, 10, 0);
      issue(CMD_READ, 2, 2, 0);
      settle();

      for (k = 0; k < PHASES; k++) begin
         set_grid(phase_w[k], phase_h[k]);
         queue_random_phase(12);
         settle();
      end

      repeat (200) @(posedge clock);
      $display("covered %0d transactions: %0d writes, %0d reads, %0d clears, %0d steps",
               checked_count, n_writes, n_reads, n_clears, n_steps);
      $display("%0d out of range coordinates across %0d grid sizes, %0d mismatches",
               n_bad, n_sizes, mismatches);
      if (predicted_results.size() != 0)
         $display("%0d expected transactions never arrived", predicted_results.size());
      if (mismatches == 0 && predicted_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
